// ===== sv/c2sv_pkg.sv =====
// Package for cartesian_to_spherical_velocity: shared types, CORDIC constants.
// No dependencies.
package c2sv_pkg;

  localparam int unsigned AngW = 32;   // binary angle, 2^32 per turn
  localparam int unsigned CrdW = 34;   // CORDIC x/y datapath (Q30 plus headroom)
  localparam logic signed [CrdW-1:0] CordicX0 = 34'sd652032874;

  // Arctangent of 2^-k in binary-angle units
  function automatic logic signed [AngW:0] atan_lut(input logic [4:0] k);
    logic signed [AngW:0] r;
    begin
      case (k)
        5'd0:  r = 33'sh20000000;
        5'd1:  r = 33'sh12E4051E;
        5'd2:  r = 33'sh09FB385B;
        5'd3:  r = 33'sh051111D4;
        5'd4:  r = 33'sh028B0D43;
        5'd5:  r = 33'sh0145D7E1;
        5'd6:  r = 33'sh00A2F61E;
        5'd7:  r = 33'sh00517C55;
        5'd8:  r = 33'sh0028BE53;
        5'd9:  r = 33'sh00145F2F;
        5'd10: r = 33'sh000A2F98;
        5'd11: r = 33'sh000517CC;
        5'd12: r = 33'sh00028BE6;
        5'd13: r = 33'sh000145F3;
        5'd14: r = 33'sh0000A2FA;
        5'd15: r = 33'sh0000517D;
        5'd16: r = 33'sh000028BE;
        5'd17: r = 33'sh0000145F;
        5'd18: r = 33'sh00000A30;
        5'd19: r = 33'sh00000518;
        5'd20: r = 33'sh0000028C;
        5'd21: r = 33'sh00000146;
        5'd22: r = 33'sh000000A3;
        5'd23: r = 33'sh00000051;
        5'd24: r = 33'sh00000029;
        5'd25: r = 33'sh00000014;
        5'd26: r = 33'sh0000000A;
        5'd27: r = 33'sh00000005;
        5'd28: r = 33'sh00000003;
        5'd29: r = 33'sh00000001;
        5'd30: r = 33'sh00000001;
        default: r = 33'sh00000000;
      endcase
      return r;
    end
  endfunction

  // One angle's CORDIC state as it moves down the row
  typedef struct packed {
    logic signed [CrdW-1:0] x;
    logic signed [CrdW-1:0] y;
    logic signed [AngW:0]   z;
    logic [1:0]             quad;
  } rot_t;

  // Payload that rides alongside the CORDIC row
  typedef struct packed {
    logic [31:0] lon;
    logic [29:0] lat;
    logic [31:0] depth;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } item_t;

endpackage

// ===== sv/c2sv_cell.sv =====
// One CORDIC micro-rotation cell handling both angles and the side payload.
// Depends on c2sv_pkg.
module c2sv_cell #(
  parameter int unsigned Stage = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  c2sv_pkg::rot_t  phi_i,
  input  c2sv_pkg::rot_t  tht_i,
  input  c2sv_pkg::item_t item_i,
  output logic            vld_o,
  output c2sv_pkg::rot_t  phi_o,
  output c2sv_pkg::rot_t  tht_o,
  output c2sv_pkg::item_t item_o
);
  import c2sv_pkg::*;

  localparam logic [4:0] K = 5'(Stage % 32);

  function automatic rot_t step(input rot_t a);
    rot_t r;
    logic signed [AngW:0] at;
    begin
      at = atan_lut(K);
      r = a;
      if (!a.z[AngW]) begin
        r.x = a.x - (a.y >>> K);
        r.y = a.y + (a.x >>> K);
        r.z = a.z - at;
      end else begin
        r.x = a.x + (a.y >>> K);
        r.y = a.y - (a.x >>> K);
        r.z = a.z + at;
      end
      return r;
    end
  endfunction

  rot_t  phi_q, tht_q;
  item_t item_q;
  logic  vld_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phi_q  <= step(phi_i);
      tht_q  <= step(tht_i);
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign phi_o  = phi_q;
  assign tht_o  = tht_q;
  assign item_o = item_q;
endmodule

// ===== sv/c2sv_proj.sv =====
// Projection back end: quadrant fix-up, base vectors, dot products, saturation.
// Pipelined over four register stages. Depends on c2sv_pkg.
module c2sv_proj #(
  parameter int unsigned SatW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            mode_i,
  input  logic            vld_i,
  input  c2sv_pkg::rot_t  phi_i,
  input  c2sv_pkg::rot_t  tht_i,
  input  c2sv_pkg::item_t item_i,
  output logic            vld_o,
  output c2sv_pkg::item_t item_o,
  output logic [31:0]     comp_a_o,
  output logic [31:0]     comp_b_o,
  output logic [31:0]     comp_c_o
);
  import c2sv_pkg::*;

  localparam int unsigned PW = 68;  // products and sums

  function automatic logic signed [CrdW:0] neg(input logic signed [CrdW-1:0] v);
    return -{v[CrdW-1], v};
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [PW-1:0] s);
    logic signed [PW-1:0] v;
    logic signed [PW-1:0] hi, lo;
    begin
      v  = (s + (PW'(1) <<< 29)) >>> 30;
      hi = (PW'(1) <<< (SatW - 1)) - PW'(1);
      lo = -hi - PW'(1);
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[31:0];
    end
  endfunction

  // Stage 1: rotate by quadrant
  logic signed [CrdW:0] cp_q, sp_q, ct_q, st_q;
  logic signed [CrdW:0] cp_d, sp_d, ct_d, st_d;
  item_t it1_q, it2_q, it3_q;
  logic v1_q, v2_q, v3_q, v4_q;

  always_comb begin
    case (phi_i.quad)
      2'd0: begin cp_d = (CrdW+1)'(phi_i.x); sp_d = (CrdW+1)'(phi_i.y); end
      2'd1: begin cp_d = neg(phi_i.y);   sp_d = (CrdW+1)'(phi_i.x); end
      2'd2: begin cp_d = neg(phi_i.x);   sp_d = neg(phi_i.y);       end
      default: begin cp_d = (CrdW+1)'(phi_i.y); sp_d = neg(phi_i.x); end
    endcase
    case (tht_i.quad)
      2'd0: begin ct_d = (CrdW+1)'(tht_i.x); st_d = (CrdW+1)'(tht_i.y); end
      2'd1: begin ct_d = neg(tht_i.y);       st_d = (CrdW+1)'(tht_i.x); end
      2'd2: begin ct_d = neg(tht_i.x);       st_d = neg(tht_i.y);       end
      default: begin ct_d = (CrdW+1)'(tht_i.y); st_d = neg(tht_i.x); end
    endcase
  end

  // Stage 2: base-vector products, rounded to Q30
  logic signed [CrdW:0] rx_q, ry_q, tx_q, ty_q, ct2_q, st2_q, cp2_q, sp2_q;
  logic signed [2*CrdW+1:0] p_rx, p_ry, p_tx, p_ty;
  assign p_rx = st_q * cp_q;
  assign p_ry = st_q * sp_q;
  assign p_tx = ct_q * cp_q;
  assign p_ty = ct_q * sp_q;

  // Stage 3: products with the vector
  logic signed [PW-1:0] m_q [8];
  // Stage 4: sums and saturation
  logic [31:0] a_q, b_q, c_q;
  logic signed [PW-1:0] vr, vt, vp;

  assign vr = m_q[0] + m_q[1] + m_q[2];
  assign vt = m_q[3] + m_q[4] - m_q[5];
  assign vp = m_q[7] - m_q[6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cp_q <= cp_d; sp_q <= sp_d; ct_q <= ct_d; st_q <= st_d;
      it1_q <= item_i;
      rx_q <= (CrdW+1)'((p_rx + (2*CrdW+2)'(1 <<< 29)) >>> 30);
      ry_q <= (CrdW+1)'((p_ry + (2*CrdW+2)'(1 <<< 29)) >>> 30);
      tx_q <= (CrdW+1)'((p_tx + (2*CrdW+2)'(1 <<< 29)) >>> 30);
      ty_q <= (CrdW+1)'((p_ty + (2*CrdW+2)'(1 <<< 29)) >>> 30);
      ct2_q <= ct_q; st2_q <= st_q; cp2_q <= cp_q; sp2_q <= sp_q;
      it2_q <= it1_q;
      m_q[0] <= PW'(rx_q * it2_q.vx);
      m_q[1] <= PW'(ry_q * it2_q.vy);
      m_q[2] <= PW'(ct2_q * it2_q.vz);
      m_q[3] <= PW'(tx_q * it2_q.vx);
      m_q[4] <= PW'(ty_q * it2_q.vy);
      m_q[5] <= PW'(st2_q * it2_q.vz);
      m_q[6] <= PW'(sp2_q * it2_q.vx);
      m_q[7] <= PW'(cp2_q * it2_q.vy);
      it3_q <= it2_q;
      if (mode_i) begin
        a_q <= sat(vp); b_q <= sat(-vt); c_q <= sat(vr);
      end else begin
        a_q <= sat(vr); b_q <= sat(vt);  c_q <= sat(vp);
      end
      item_o <= it3_q;
    end
  end

  assign vld_o    = v4_q;
  assign comp_a_o = a_q;
  assign comp_b_o = b_q;
  assign comp_c_o = c_q;
endmodule

// ===== sv/cartesian_to_spherical_velocity.sv =====
// Cartesian-to-spherical vector rotation, streaming top level.
// Throughput one item per cycle (three-stage angle conversion, cell row plus
// four-stage projection, all advancing together; stall only when the output
// register is full and not taken).
// Reset clears valids and output_mode.
// Depends on c2sv_pkg, c2sv_cell, c2sv_proj.
module cartesian_to_spherical_velocity #(
  parameter int unsigned CORDIC_STAGES = 24,
  parameter int unsigned VEC_WIDTH     = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_data_i,     // output_mode
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] longitude, [61:32] latitude, [93:62] depth,
  // [125:94] vel_x, [157:126] vel_y, [189:158] vel_z
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] longitude_out, [61:32] latitude_out, [93:62] depth_out,
  // [125:94] comp_a, [157:126] comp_b, [189:158] comp_c
  output logic [191:0] m_axis_tdata
);
  import c2sv_pkg::*;

  localparam int unsigned SatW = (VEC_WIDTH > 32) ? 32 : VEC_WIDTH;

  logic mode_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= 1'b0;
    else if (cfg_valid_i) mode_q <= cfg_data_i;
  end
  assign cfg_ready_o = 1'b1;

  // Whole pipe advances unless the output holds an untaken item
  logic en;
  logic ovld_q;
  assign en = !ovld_q || m_axis_tready;
  assign s_axis_tready = en;

  item_t in_item;
  assign in_item.lon   = s_axis_tdata[31:0];
  assign in_item.lat   = s_axis_tdata[61:32];
  assign in_item.depth = s_axis_tdata[93:62];
  assign in_item.vx    = s_axis_tdata[125:94];
  assign in_item.vy    = s_axis_tdata[157:126];
  assign in_item.vz    = s_axis_tdata[189:158];

  // Degrees (2^-22) to binary angle: floor((d*1024+180)/360) mod 2^32, which
  // equals floor((128*d+22)/45) mod 2^32. Adding 45*2^33 keeps the dividend
  // positive and leaves the low 32 quotient bits alone.
  function automatic logic [39:0] ang_num(input logic signed [32:0] d);
    logic signed [41:0] t;
    begin
      t = ($signed({{9{d[32]}}, d}) <<< 7) + 42'sd22 + 42'sd386547056640;
      return t[39:0];
    end
  endfunction

  // Divide by 45, upper 20 bits: {quotient, remainder, lower 20 bits}
  function automatic logic [40:0] div45_hi(input logic [39:0] n);
    logic [40:0] p;
    logic [14:0] qh;
    logic [19:0] rh;
    begin
      p  = 41'(n[39:20]) * 41'd1491309;  // ceil(2^26/45)
      qh = p[40:26];
      rh = n[39:20] - 20'(qh) * 20'd45;
      return {qh, rh[5:0], n[19:0]};
    end
  endfunction

  // Divide by 45, remainder joined with the lower 20 bits
  function automatic logic [AngW-1:0] div45_lo(input logic [40:0] h);
    logic [52:0] p;
    begin
      p = 53'(h[25:0]) * 53'd95443718;  // ceil(2^32/45)
      return {h[37:26], p[51:32]};
    end
  endfunction

  // Input stages: angle conversion over three registers, then CORDIC seed
  logic signed [32:0] thd;
  logic [39:0] np_q, nt_q;
  logic [40:0] hp_q, ht_q;
  logic [AngW-1:0] bp_q, bt_q;
  item_t ita_q, itb_q, it0_q;
  logic va_q, vb_q, v0_q;
  assign thd = 33'sd377487360 - {{3{in_item.lat[29]}}, in_item.lat};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      v0_q <= 1'b0;
    end else if (en) begin
      va_q <= s_axis_tvalid;
      vb_q <= va_q;
      v0_q <= vb_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      np_q  <= ang_num({in_item.lon[31], in_item.lon});
      nt_q  <= ang_num(thd);
      ita_q <= in_item;
      hp_q  <= div45_hi(np_q);
      ht_q  <= div45_hi(nt_q);
      itb_q <= ita_q;
      bp_q  <= div45_lo(hp_q);
      bt_q  <= div45_lo(ht_q);
      it0_q <= itb_q;
    end
  end

  function automatic rot_t seed(input logic [AngW-1:0] b);
    rot_t r;
    logic [AngW-1:0] s;
    begin
      s = b + 32'h20000000;
      r.quad = s[31:30];
      r.x = CordicX0;
      r.y = '0;
      r.z = {1'b0, b - {s[31:30], 30'd0}};
      r.z = (AngW+1)'($signed(r.z[AngW-1:0]));
      return r;
    end
  endfunction

  rot_t  phi_c [CORDIC_STAGES+1];
  rot_t  tht_c [CORDIC_STAGES+1];
  item_t it_c  [CORDIC_STAGES+1];
  logic  v_c   [CORDIC_STAGES+1];

  assign phi_c[0] = seed(bp_q);
  assign tht_c[0] = seed(bt_q);
  assign it_c[0]  = it0_q;
  assign v_c[0]   = v0_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_row
    c2sv_cell #(.Stage(g)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(v_c[g]), .phi_i(phi_c[g]), .tht_i(tht_c[g]), .item_i(it_c[g]),
      .vld_o(v_c[g+1]), .phi_o(phi_c[g+1]), .tht_o(tht_c[g+1]), .item_o(it_c[g+1])
    );
  end

  item_t it_o;
  logic [31:0] ca, cb, cc;
  c2sv_proj #(.SatW(SatW)) u_proj (
    .clk_i, .rst_ni, .en_i(en), .mode_i(mode_q),
    .vld_i(v_c[CORDIC_STAGES]), .phi_i(phi_c[CORDIC_STAGES]),
    .tht_i(tht_c[CORDIC_STAGES]), .item_i(it_c[CORDIC_STAGES]),
    .vld_o(ovld_q), .item_o(it_o),
    .comp_a_o(ca), .comp_b_o(cb), .comp_c_o(cc)
  );

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {2'b00, cc, cb, ca, it_o.depth, it_o.lat, it_o.lon};
endmodule
